FILE: rtl/linear_queue_with_search_unit_macros.svh
// assertion macros shared by the queue checker
`ifndef LINEAR_QUEUE_WITH_SEARCH_UNIT_MACROS_SVH
`define LINEAR_QUEUE_WITH_SEARCH_UNIT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define LQS_ASSERT_NOW(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("queue check failed");

// consequence that must hold in the cycle after the antecedent
`define LQS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue check failed");

`endif

FILE: rtl/lqs_pkg.sv
// shared types and codes for the linear queue with search
package lqs_pkg;

  // command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DEL    = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int DATA_W = 32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch;       // capture the incoming transaction
    logic add;         // perform an add
    logic del_start;   // start a delete: read head entry or flag empty
    logic pop;         // finish a delete: take data, advance head
    logic scan_first;  // read the head slot for a search
    logic scan_next;   // read the slot after the last one read
    logic hit;         // record the slot just compared as a match
    logic out_load;    // move the result into the output register
  } lqs_ctrl_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [1:0] cmd;       // latched command
    logic       empty;     // queue holds no entries
    logic       match;     // last read entry equals the search value
    logic       last;      // last read slot is the tail
    logic       out_free;  // output register can take a result
  } lqs_stat_t;

endpackage

FILE: rtl/lqs_ctrl.sv
// controller state machine for the linear queue with search
module lqs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lqs_pkg::lqs_stat_t stat,
  output lqs_pkg::lqs_ctrl_t ctl
);
  import lqs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_READ  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        case (stat.cmd)
          CMD_ADD: begin
            ctl.add    = 1'b1;
            state_next = S_DONE;
          end
          CMD_DEL: begin
            ctl.del_start = 1'b1;
            state_next    = stat.empty ? S_DONE : S_READ;
          end
          CMD_SEARCH: begin
            if (stat.empty) begin
              state_next = S_DONE;
            end else begin
              ctl.scan_first = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_READ: begin
        ctl.pop    = 1'b1;
        state_next = S_DONE;
      end
      S_SCAN: begin
        if (stat.match) begin
          ctl.hit    = 1'b1;
          state_next = S_DONE;
        end else if (stat.last) begin
          state_next = S_DONE;
        end else begin
          ctl.scan_next = 1'b1;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/lqs_datapath.sv
// pointers, entry memory, scan compare and result registers
module lqs_datapath #(
  parameter  int DEPTH = 16,
  localparam int SW    = $clog2(DEPTH + 1),
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lqs_pkg::lqs_ctrl_t                ctl,
  output lqs_pkg::lqs_stat_t                stat,
  input  logic [1:0]                        command,
  input  logic signed [lqs_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic signed [lqs_pkg::DATA_W-1:0] data_out,
  output logic                              found,
  output logic [SW-1:0]                     found_slot,
  output logic [SW-1:0]                     count,
  output logic                              is_empty,
  output logic                              is_full
);
  import lqs_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  logic [1:0]               cmd;
  logic signed [DATA_W-1:0] val;
  logic [SW-1:0]            head, tail;
  logic signed [DATA_W-1:0] rd_data;
  logic [SW-1:0]            rd_slot;
  logic [1:0]               res_status;
  logic signed [DATA_W-1:0] res_data;
  logic                     res_found;
  logic [SW-1:0]            res_slot;

  logic          q_empty, q_full;
  logic [SW-1:0] head_m1, q_count;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;

  // queue flags
  assign q_empty = (head == '0) && (tail == '0);
  assign q_full  = (tail == SW'(DEPTH));
  assign q_count = q_empty ? '0 : (tail + SW'(1) - head);
  assign head_m1 = head - SW'(1);

  // memory port addressing
  assign wr_en   = ctl.add && !q_full;
  assign wr_addr = q_empty ? '0 : tail[AW-1:0];
  assign rd_en   = (ctl.del_start && !q_empty) || ctl.scan_first || ctl.scan_next;
  assign rd_addr = ctl.scan_next ? rd_slot[AW-1:0] : head_m1[AW-1:0];

  // entry memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= val;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_slot <= ctl.scan_next ? (rd_slot + SW'(1)) : head;
    end
  end

  // head and tail pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else if (ctl.add) begin
      if (q_empty) begin
        head <= SW'(1);
        tail <= SW'(1);
      end else if (!q_full) begin
        tail <= tail + SW'(1);
      end
    end else if (ctl.pop) begin
      if (head == tail) begin
        head <= '0;
        tail <= '0;
      end else begin
        head <= head + SW'(1);
      end
    end
  end

  // captured transaction and pending result
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd        <= command;
      val        <= value;
      res_status <= ST_OK;
      res_data   <= '0;
      res_found  <= 1'b0;
      res_slot   <= '0;
    end
    if (ctl.add && q_full) begin
      res_status <= ST_FULL;
    end
    if (ctl.del_start && q_empty) begin
      res_status <= ST_EMPTY;
    end
    if (ctl.pop) begin
      res_data <= rd_data;
    end
    if (ctl.hit) begin
      res_found <= 1'b1;
      res_slot  <= rd_slot;
    end
  end

  // output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status     <= res_status;
      data_out   <= res_data;
      found      <= res_found;
      found_slot <= res_slot;
      count      <= q_count;
      is_empty   <= q_empty;
      is_full    <= q_full;
    end
  end

  // status back to the controller
  assign stat.cmd      = cmd;
  assign stat.empty    = q_empty;
  assign stat.match    = (rd_data == val);
  assign stat.last     = (rd_slot == tail);
  assign stat.out_free = !out_valid || out_ready;

endmodule

FILE: rtl/linear_queue_with_search_unit.sv
// top level of the linear queue with search
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  input    | in_valid / in_ready  | command, value
//  output   | out_valid / out_ready| status, data_out, found, found_slot, count,
//           |                      | is_empty, is_full
//
// one transaction is worked on at a time; add steps through START and DONE, delete
// through START, READ and DONE, search through START, SCAN per slot (at most DEPTH)
// and DONE; the single entry memory read port lets the scan walk one slot a cycle.
// rst is synchronous and empties the queue; entry memory is not cleared.
// a result waiting in the output register does not block the next transaction;
// only the following result waits for out_ready.
module linear_queue_with_search_unit #(
  parameter  int DEPTH = 16,
  localparam int SW    = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        command,
  input  logic signed [lqs_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic signed [lqs_pkg::DATA_W-1:0] data_out,
  output logic                              found,
  output logic [SW-1:0]                     found_slot,
  output logic [SW-1:0]                     count,
  output logic                              is_empty,
  output logic                              is_full
);
  import lqs_pkg::*;

  lqs_ctrl_t ctl;
  lqs_stat_t stat;

  // sequencer
  lqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // storage and result path
  lqs_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .command    (command),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .data_out   (data_out),
    .found      (found),
    .found_slot (found_slot),
    .count      (count),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

endmodule

FILE: rtl/lqs_checker.sv
// port-level checks for the linear queue with search, bound to the top level
`include "linear_queue_with_search_unit_macros.svh"

module lqs_checker #(
  parameter  int DEPTH = 16,
  localparam int SW    = $clog2(DEPTH + 1)
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [1:0]                        status,
  input logic signed [lqs_pkg::DATA_W-1:0] data_out,
  input logic                              found,
  input logic [SW-1:0]                     found_slot,
  input logic [SW-1:0]                     count,
  input logic                              is_empty,
  input logic                              is_full
);
  import lqs_pkg::*;

  logic out_stall;
  logic refuse_ok;
  logic slot_ok;

  // result held back by the receiver
  assign out_stall = out_valid && !out_ready;

  // refused delete shape: empty queue, no data, no match
  assign refuse_ok = is_empty && (data_out == '0) && !found;

  // match shape: real slot, non-empty queue, ok status
  assign slot_ok = (found_slot != '0) && (found_slot <= SW'(DEPTH)) && !is_empty &&
                   (status == ST_OK);

  // a stalled result holds
  `LQS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable({status, data_out, count}))

  // empty flag agrees with the entry count
  `LQS_ASSERT_NOW(a_empty_count, !out_valid || (is_empty == (count == '0)))

  // a refused add only happens on a full queue
  `LQS_ASSERT_NOW(a_full_refuse, !out_valid || status != ST_FULL || (is_full && !is_empty))

  // a refused delete leaves an empty queue and no data
  `LQS_ASSERT_NOW(a_empty_refuse, !out_valid || status != ST_EMPTY || refuse_ok)

  // a match names a real slot of a non-empty queue
  `LQS_ASSERT_NOW(a_found_slot, !out_valid || !found || slot_ok)

endmodule

bind linear_queue_with_search_unit lqs_checker #(.DEPTH(DEPTH)) u_lqs_checker (.*);

FILE: sim/linear_queue_with_search_unit_test.sv
// self-checking testbench for the linear queue with search, directed and random transactions
`timescale 1ns / 1ps

module linear_queue_with_search_unit_test;
  import lqs_pkg::*;

  localparam int DEPTH = 16;
  localparam int SW = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 1030;
  localparam int QUIET_ITEMS = 150;

  typedef struct {
    logic [1:0]        status;
    logic [DATA_W-1:0] data_out;
    logic              found;
    logic [SW-1:0]     found_slot;
    logic [SW-1:0]     count;
    logic              is_empty;
    logic              is_full;
  } queue_result_t;

  // mirror of the queue contents and the results still owed by the block
  class queue_scoreboard;
    logic [SW-1:0]     head;
    logic [SW-1:0]     tail;
    logic [DATA_W-1:0] slots [1:DEPTH];
    queue_result_t     pending_results[$];
    int                mismatches;

    function new();
      head = '0;
      tail = '0;
      mismatches = 0;
    endfunction

    // update the mirror for one command and return the result it must give
    function queue_result_t apply_command(logic [1:0] cmd, logic [DATA_W-1:0] val);
      queue_result_t r;
      bit            was_empty;
      int            s;
      r.status = ST_OK;
      r.data_out = '0;
      r.found = 1'b0;
      r.found_slot = '0;
      was_empty = (head == 0) && (tail == 0);
      case (cmd)
        CMD_ADD: begin
          if (was_empty) begin
            head = 1;
            tail = 1;
            slots[1] = val;
          end else if (tail == DEPTH) begin
            r.status = ST_FULL;
          end else begin
            tail = tail + 1'b1;
            slots[tail] = val;
          end
        end
        CMD_DEL: begin
          if (was_empty) begin
            r.status = ST_EMPTY;
          end else begin
            r.data_out = slots[head];
            if (head == tail) begin
              head = '0;
              tail = '0;
            end else begin
              head = head + 1'b1;
            end
          end
        end
        CMD_SEARCH: begin
          // scan runs from head to tail, first match wins
          if (!was_empty) begin
            for (s = head; s <= tail && !r.found; s++) begin
              if (slots[s] == val) begin
                r.found = 1'b1;
                r.found_slot = s[SW-1:0];
              end
            end
          end
        end
        default: ;
      endcase
      r.is_empty = (head == 0) && (tail == 0);
      r.is_full = (tail == DEPTH);
      r.count = r.is_empty ? '0 : SW'(tail + 1 - head);
      return r;
    endfunction

    function void note_command(logic [1:0] cmd, logic [DATA_W-1:0] val);
      pending_results.push_back(apply_command(cmd, val));
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t exp;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no transaction outstanding, status %0d", $realtime,
                   got.status);
        return;
      end
      exp = pending_results.pop_front();
      if (got.status !== exp.status || got.data_out !== exp.data_out ||
          got.found !== exp.found || got.found_slot !== exp.found_slot ||
          got.count !== exp.count || got.is_empty !== exp.is_empty ||
          got.is_full !== exp.is_full) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected status %0d data %h found %b slot %0d count %0d empty %b full %b",
                   exp.status, exp.data_out, exp.found, exp.found_slot, exp.count,
                   exp.is_empty, exp.is_full);
          $display("  actual   status %0d data %h found %b slot %0d count %0d empty %b full %b",
                   got.status, got.data_out, got.found, got.found_slot, got.count,
                   got.is_empty, got.is_full);
        end
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               command = CMD_ADD;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data_out;
  logic                     found;
  logic [SW-1:0]            found_slot;
  logic [SW-1:0]            count;
  logic                     is_empty;
  logic                     is_full;

  queue_scoreboard sb = new();
  queue_result_t   seen_result;
  bit              quiet_tail = 1'b0;
  int              ready_left = 0;
  logic [DATA_W-1:0] recent_adds [8];
  int              recent_idx = 0;

  linear_queue_with_search_unit #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .data_out(data_out),
    .found(found),
    .found_slot(found_slot),
    .count(count),
    .is_empty(is_empty),
    .is_full(is_full)
  );

  always #2 clk = ~clk;

  // receiver: ready stretches broken by stall bursts, always ready near the end
  always @(posedge clk) begin
    if (quiet_tail) begin
      out_ready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      ready_left = $urandom_range(0, 14);
    end else begin
      out_ready <= 1'b1;
      ready_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(0, 39);
    end
  end

  // monitor: check results first, then note the accepted command
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen_result.status = status;
        seen_result.data_out = data_out;
        seen_result.found = found;
        seen_result.found_slot = found_slot;
        seen_result.count = count;
        seen_result.is_empty = is_empty;
        seen_result.is_full = is_full;
        sb.check_result(seen_result);
      end
      if (in_valid && in_ready)
        sb.note_command(command, value);
    end
  end

  task automatic send_command(input logic [1:0] cmd, input logic [DATA_W-1:0] val);
    in_valid <= 1'b1;
    command <= cmd;
    value <= val;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_ADD) begin
      recent_adds[recent_idx] = val;
      recent_idx = (recent_idx + 1) % 8;
    end
  endtask

  task automatic hold_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // half the values are small repeats or extremes so that searches hit
  function automatic logic [DATA_W-1:0] pick_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return DATA_W'($urandom_range(0, 5)) - 3;
    if (pick == 4) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  // directed: empty cases, extremes, search order, fill to full
  task automatic directed_traffic();
    send_command(CMD_DEL, $urandom);
    send_command(CMD_SEARCH, 32'h0);
    send_command(CMD_ADD, 32'h8000_0000);
    send_command(CMD_SEARCH, 32'h8000_0000);
    send_command(CMD_DEL, $urandom);
    send_command(CMD_ADD, 32'h7fff_ffff);
    send_command(CMD_ADD, 32'hffff_ffff);
    send_command(CMD_ADD, 32'h0);
    send_command(CMD_ADD, 32'h7fff_ffff);
    send_command(CMD_SEARCH, 32'h7fff_ffff);
    send_command(CMD_DEL, $urandom);
    // head has moved past slot 1, match must be in slot 4
    send_command(CMD_SEARCH, 32'h7fff_ffff);
    send_command(CMD_SEARCH, 32'h1234_5678);
    repeat (12) send_command(CMD_ADD, $urandom);
    // tail at last slot with head moved on: still refused
    send_command(CMD_ADD, $urandom);
  endtask

  // random: alternating fill and drain phases so full and empty both recur
  task automatic random_traffic(input int n_items);
    int               i;
    int               phase_left;
    int               roll;
    bit               filling;
    bit               idling;
    logic [1:0]       cmd;
    logic [DATA_W-1:0] val;
    phase_left = 0;
    filling = 1'b1;
    idling = 1'b1;
    for (i = 0; i < n_items; i++) begin
      if (phase_left == 0) begin
        filling = !filling;
        phase_left = $urandom_range(10, 60);
      end
      phase_left--;
      if (i % 100 == 0) idling = ($urandom_range(0, 3) != 0);
      if (i >= n_items - QUIET_ITEMS) quiet_tail = 1'b1;
      roll = $urandom_range(0, 99);
      if (filling) cmd = (roll < 65) ? CMD_ADD : (roll < 85) ? CMD_DEL : CMD_SEARCH;
      else cmd = (roll < 20) ? CMD_ADD : (roll < 80) ? CMD_DEL : CMD_SEARCH;
      if (cmd == CMD_SEARCH && $urandom_range(0, 9) < 7)
        val = recent_adds[$urandom_range(0, 7)];
      else
        val = pick_value();
      if (!quiet_tail && idling && $urandom_range(0, 5) == 0)
        hold_input($urandom_range(1, 15));
      send_command(cmd, val);
    end
  endtask

  initial begin
    foreach (recent_adds[k]) recent_adds[k] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    directed_traffic();
    random_traffic(RANDOM_ITEMS);
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (3 * DEPTH) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lqs_pkg.sv
rtl/lqs_ctrl.sv
rtl/lqs_datapath.sv
rtl/linear_queue_with_search_unit.sv
rtl/lqs_checker.sv
sim/linear_queue_with_search_unit_test.sv
